FILE: rtl/scld_pkg.sv
// Package: shared types and constants for the serial command line decoder.
package scld_pkg;

  localparam int unsigned LineCapacity = 63;
  localparam int unsigned AddrW = 6;
  localparam int unsigned KeywordCount = 17;
  localparam int unsigned KeyMaxLen = 11;

  localparam logic [4:0] CodeUnknown = 5'd17;
  localparam logic [4:0] CodeBlank = 5'd18;

  localparam logic [7:0] ChBs = 8'h08;
  localparam logic [7:0] ChDel = 8'h7F;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChNul = 8'h00;
  localparam logic [7:0] ChPlus = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChCrMax = 8'h0D;
  localparam logic [7:0] ChO = 8'h4F;
  localparam logic [7:0] ChN = 8'h4E;
  localparam logic [7:0] ChF = 8'h46;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StScan,
    StOut
  } state_e;

  // Token scan phase
  typedef enum logic [2:0] {
    PhLead1,
    PhTok1,
    PhLead2,
    PhTok2,
    PhDone
  } phase_e;

  // Number parse phase
  typedef enum logic [1:0] {
    NumWs,
    NumSign,
    NumDigits,
    NumStop
  } num_e;

  // Keyword character at position p (0 = past end)
  function automatic logic [7:0] kw_char(input logic [4:0] k, input logic [3:0] p);
    logic [8*KeyMaxLen-1:0] s;
    logic [3:0] n;
    begin
      s = '0;
      n = 4'd0;
      case (k)
        5'd0:  begin s[8*3-1:0]  = "LED";         n = 4'd3;  end
        5'd1:  begin s[8*8-1:0]  = "INTERVAL";    n = 4'd8;  end
        5'd2:  begin s[8*5-1:0]  = "HELLO";       n = 4'd5;  end
        5'd3:  begin s[8*4-1:0]  = "DUMP";        n = 4'd4;  end
        5'd4:  begin s[8*4-1:0]  = "HELP";        n = 4'd4;  end
        5'd5:  begin s[8*6-1:0]  = "UPTIME";      n = 4'd6;  end
        5'd6:  begin s[8*6-1:0]  = "BRIGHT";      n = 4'd6;  end
        5'd7:  begin s[8*6-1:0]  = "STATUS";      n = 4'd6;  end
        5'd8:  begin s[8*6-1:0]  = "BREATH";      n = 4'd6;  end
        5'd9:  begin s[8*5-1:0]  = "BLINK";       n = 4'd5;  end
        5'd10: begin s[8*11-1:0] = "BREATHSPEED"; n = 4'd11; end
        5'd11: begin s[8*5-1:0]  = "RESET";       n = 4'd5;  end
        5'd12: begin s[8*5-1:0]  = "TIMER";       n = 4'd5;  end
        5'd13: begin s[8*3-1:0]  = "ENV";         n = 4'd3;  end
        5'd14: begin s[8*6-1:0]  = "REPORT";      n = 4'd6;  end
        5'd15: begin s[8*5-1:0]  = "DEBUG";       n = 4'd5;  end
        5'd16: begin s[8*8-1:0]  = "SENSSTAT";    n = 4'd8;  end
        default: begin s = '0; n = 4'd0; end
      endcase
      if (p >= n) begin
        kw_char = ChNul;
      end else begin
        kw_char = s[8*(n-p)-1 -: 8];
      end
    end
  endfunction

endpackage

FILE: rtl/scld_ram.sv
// Generic single-port-write, registered-read RAM.
module scld_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/serial_command_line_decoder_core.sv
// Top level: serial command line collector and decoder.
// An ordinary character or a backspace word is taken directly in the idle
// state; a backspace on a non-empty line produces an erase-echo
// word through the output register on the next cycle. CR or LF on a
// non-empty line starts a walk over the stored line in the line RAM that
// reads each character and then scans the read data, ending early at the
// first NUL or after the second token; no input word is taken during that
// walk or while a result waits on the output.
module serial_command_line_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        ev_valid_o,
  input  logic        ev_stall_i,
  output logic        event_kind_o,
  output logic [4:0]  command_code_o,
  output logic        arg_present_o,
  output logic        arg_is_on_o,
  output logic        arg_is_off_o,
  output logic signed [31:0] arg_value_o
);

  localparam logic [6:0] Cap = 7'(scld_pkg::LineCapacity);

  scld_pkg::state_e state_q, state_d;
  scld_pkg::phase_e ph_q, ph_d;
  scld_pkg::num_e   num_q, num_d;

  logic [6:0] fill_q, fill_d;
  logic [6:0] len_q, len_d;
  logic [6:0] pos_q, pos_d;
  logic [3:0] t1len_q, t1len_d;
  logic       t1long_q, t1long_d;
  logic [16:0] kwok_q, kwok_d;
  logic [1:0] t2len_q, t2len_d;
  logic       t2long_q, t2long_d;
  logic       on_q, on_d, off_q, off_d;
  logic       neg_q, neg_d;
  logic [31:0] mag_q, mag_d;

  logic        vld_q, vld_d;
  logic        kind_q, kind_d;
  logic [4:0]  code_q, code_d;
  logic        pres_q, pres_d, ion_q, ion_d, ioff_q, ioff_d;
  logic [31:0] val_q, val_d;

  logic       we;
  logic [5:0] waddr, raddr;
  logic [7:0] rdata;
  logic       acc;
  logic [35:0] mul10;
  logic [35:0] mag_n;

  scld_ram #(.Width(8), .Depth(64)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (rx_byte_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rx_stall_o = (state_q != scld_pkg::StIdle) || vld_q;
  assign acc = rx_valid_i && !rx_stall_o;
  assign raddr = pos_q[5:0];
  assign waddr = fill_q[5:0];
  assign mul10 = {4'd0, mag_q} * 36'd10;
  assign mag_n = mul10 + {28'd0, rdata - scld_pkg::ChZero};

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scld_pkg::StIdle;
      fill_q <= '0;
      vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q <= fill_d;
      vld_q <= vld_d;
    end
  end

  // Scan and output payload registers
  always_ff @(posedge clk_i) begin
    ph_q <= ph_d; num_q <= num_d; len_q <= len_d; pos_q <= pos_d;
    t1len_q <= t1len_d; t1long_q <= t1long_d; kwok_q <= kwok_d;
    t2len_q <= t2len_d; t2long_q <= t2long_d; on_q <= on_d; off_q <= off_d;
    neg_q <= neg_d; mag_q <= mag_d;
    kind_q <= kind_d; code_q <= code_d; pres_q <= pres_d;
    ion_q <= ion_d; ioff_q <= ioff_d; val_q <= val_d;
  end

  // Next state: collect, walk the line, emit
  always_comb begin
    state_d = state_q; fill_d = fill_q; vld_d = vld_q;
    ph_d = ph_q; num_d = num_q; len_d = len_q; pos_d = pos_q;
    t1len_d = t1len_q; t1long_d = t1long_q; kwok_d = kwok_q;
    t2len_d = t2len_q; t2long_d = t2long_q; on_d = on_q; off_d = off_q;
    neg_d = neg_q; mag_d = mag_q;
    kind_d = kind_q; code_d = code_q; pres_d = pres_q;
    ion_d = ion_q; ioff_d = ioff_q; val_d = val_q;
    we = 1'b0;
    if (vld_q && !ev_stall_i) begin
      vld_d = 1'b0;
    end
    case (state_q)
      scld_pkg::StIdle: begin
        if (acc) begin
          if (rx_byte_i == scld_pkg::ChCr || rx_byte_i == scld_pkg::ChLf) begin
            if (fill_q != 7'd0) begin
              len_d = fill_q; pos_d = '0;
              ph_d = scld_pkg::PhLead1; num_d = scld_pkg::NumWs;
              t1len_d = '0; t1long_d = 1'b0; kwok_d = '1;
              t2len_d = '0; t2long_d = 1'b0; on_d = 1'b1; off_d = 1'b1;
              neg_d = 1'b0; mag_d = '0;
              state_d = scld_pkg::StRead;
            end
          end else if (rx_byte_i == scld_pkg::ChBs || rx_byte_i == scld_pkg::ChDel) begin
            if (fill_q != 7'd0) begin
              fill_d = fill_q - 7'd1;
              vld_d = 1'b1; kind_d = 1'b0; code_d = '0; pres_d = 1'b0;
              ion_d = 1'b0; ioff_d = 1'b0; val_d = '0;
            end
          end else if (fill_q < Cap) begin
            we = 1'b1;
            fill_d = fill_q + 7'd1;
          end
        end
      end
      scld_pkg::StRead: begin
        // prime the read of the current position
        state_d = scld_pkg::StScan;
      end
      scld_pkg::StScan: begin
        if (pos_q >= len_q || rdata == scld_pkg::ChNul) begin
          state_d = scld_pkg::StOut;
        end else begin
          pos_d = pos_q + 7'd1;
          state_d = scld_pkg::StRead;
          case (ph_q)
            scld_pkg::PhLead1, scld_pkg::PhTok1: begin
              if (rdata == scld_pkg::ChSpace) begin
                if (ph_q == scld_pkg::PhTok1) ph_d = scld_pkg::PhLead2;
              end else begin
                ph_d = scld_pkg::PhTok1;
                for (int k = 0; k < scld_pkg::KeywordCount; k++) begin
                  if (t1long_q ||
                      scld_pkg::kw_char(5'(k), t1len_q) != rdata) begin
                    kwok_d[k] = 1'b0;
                  end
                end
                if (t1len_q == 4'd11) t1long_d = 1'b1;
                else t1len_d = t1len_q + 4'd1;
              end
            end
            scld_pkg::PhLead2, scld_pkg::PhTok2: begin
              if (rdata == scld_pkg::ChSpace) begin
                if (ph_q == scld_pkg::PhTok2) ph_d = scld_pkg::PhDone;
              end else begin
                ph_d = scld_pkg::PhTok2;
                if (t2long_q || t2len_q == 2'd3) begin
                  t2long_d = 1'b1; on_d = 1'b0; off_d = 1'b0;
                end else begin
                  if (!(t2len_q == 2'd0 && rdata == scld_pkg::ChO) &&
                      !(t2len_q == 2'd1 && rdata == scld_pkg::ChN)) on_d = 1'b0;
                  if (!(t2len_q == 2'd0 && rdata == scld_pkg::ChO) &&
                      !(t2len_q != 2'd0 && rdata == scld_pkg::ChF)) off_d = 1'b0;
                  t2len_d = t2len_q + 2'd1;
                end
                // atoi walk
                if (num_q == scld_pkg::NumWs &&
                    rdata >= scld_pkg::ChTab && rdata <= scld_pkg::ChCrMax) begin
                  num_d = scld_pkg::NumWs;
                end else if ((num_q == scld_pkg::NumWs) &&
                    (rdata == scld_pkg::ChPlus || rdata == scld_pkg::ChMinus)) begin
                  neg_d = (rdata == scld_pkg::ChMinus);
                  num_d = scld_pkg::NumDigits;
                end else if (num_q != scld_pkg::NumStop &&
                    rdata >= scld_pkg::ChZero && rdata <= scld_pkg::ChNine) begin
                  num_d = scld_pkg::NumDigits;
                  mag_d = (mag_n > 36'h8000_0000) ? 32'h8000_0000 : mag_n[31:0];
                end else begin
                  num_d = scld_pkg::NumStop;
                end
              end
            end
            default: begin
              pos_d = len_q;
            end
          endcase
        end
      end
      scld_pkg::StOut: begin
        if (!vld_q) begin
          vld_d = 1'b1; kind_d = 1'b1;
          code_d = scld_pkg::CodeBlank; pres_d = 1'b0;
          ion_d = 1'b0; ioff_d = 1'b0; val_d = '0;
          if (t1len_q != 4'd0) begin
            code_d = scld_pkg::CodeUnknown;
            for (int k = scld_pkg::KeywordCount - 1; k >= 0; k--) begin
              if (kwok_q[k] && !t1long_q &&
                  scld_pkg::kw_char(5'(k), t1len_q) == scld_pkg::ChNul) begin
                code_d = 5'(k);
              end
            end
            if (t2len_q != 2'd0) begin
              pres_d = 1'b1;
              ion_d = on_q && !t2long_q && t2len_q == 2'd2;
              ioff_d = off_q && !t2long_q && t2len_q == 2'd3;
              if (neg_q) val_d = 32'd0 - mag_q;
              else val_d = (mag_q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag_q;
            end
          end
          fill_d = '0;
          state_d = scld_pkg::StIdle;
        end
      end
      default: state_d = scld_pkg::StIdle;
    endcase
  end

  assign ev_valid_o = vld_q;
  assign event_kind_o = kind_q;
  assign command_code_o = code_q;
  assign arg_present_o = pres_q;
  assign arg_is_on_o = ion_q;
  assign arg_is_off_o = ioff_q;
  assign arg_value_o = val_q;

  // Checks
  a_fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= Cap) else $error("fill count beyond capacity");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != scld_pkg::StIdle) |-> rx_stall_o) else $error("input taken while walking");
  a_line_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev_valid_o && !$past(ev_valid_o) && event_kind_o) |-> fill_q == 7'd0)
    else $error("line not cleared after decode");

endmodule

FILE: tb/sv/serial_command_line_decoder_core_chk.sv
// Checker: predicts decoded-line and erase-echo words from rx words; compares event channel.
module serial_command_line_decoder_core_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  input  logic        rx_stall_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        ev_valid_i,
  input  logic        ev_stall_i,
  input  logic        event_kind_i,
  input  logic [4:0]  command_code_i,
  input  logic        arg_present_i,
  input  logic        arg_is_on_i,
  input  logic        arg_is_off_i,
  input  logic signed [31:0] arg_value_i,
  output int          err_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic        kind;
    logic [4:0]  code;
    logic        present;
    logic        is_on;
    logic        is_off;
    logic [31:0] value;
  } event_t;

  event_t     event_q[$];
  logic [7:0] line_buf[scld_pkg::LineCapacity];
  int         line_len;

  // Compare a token with a keyword string
  function automatic bit tok_is(int s, int l, string w);
    if (l != w.len()) return 0;
    for (int i = 0; i < l; i++) begin
      if (line_buf[s+i] != w[i]) return 0;
    end
    return 1;
  endfunction

  // Decimal value with atoi rules, saturated to 32 bits
  function automatic logic [31:0] tok_value(int s, int l);
    int          i;
    bit          neg;
    longint      mag;
    i = 0;
    neg = 0;
    mag = 0;
    while (i < l && line_buf[s+i] >= 8'h09 && line_buf[s+i] <= 8'h0D) i++;
    if (i < l && (line_buf[s+i] == "+" || line_buf[s+i] == "-")) begin
      neg = (line_buf[s+i] == "-");
      i++;
    end
    while (i < l && line_buf[s+i] >= "0" && line_buf[s+i] <= "9") begin
      mag = mag * 10 + (line_buf[s+i] - "0");
      if (mag > 64'd2147483648) mag = 64'd2147483648;
      i++;
    end
    if (!neg && mag > 64'd2147483647) mag = 64'd2147483647;
    if (neg) mag = -mag;
    return mag[31:0];
  endfunction

  // Split the stored line and decode the command word
  function automatic event_t decode_line();
    string  kw[scld_pkg::KeywordCount] = '{"LED", "INTERVAL", "HELLO", "DUMP", "HELP",
      "UPTIME", "BRIGHT", "STATUS", "BREATH", "BLINK", "BREATHSPEED", "RESET", "TIMER",
      "ENV", "REPORT", "DEBUG", "SENSSTAT"};
    event_t e;
    int     n, p, s1, l1, s2, l2;
    n = 0;
    while (n < line_len && line_buf[n] != scld_pkg::ChNul) n++;
    p = 0;
    while (p < n && line_buf[p] == scld_pkg::ChSpace) p++;
    s1 = p;
    while (p < n && line_buf[p] != scld_pkg::ChSpace) p++;
    l1 = p - s1;
    while (p < n && line_buf[p] == scld_pkg::ChSpace) p++;
    s2 = p;
    while (p < n && line_buf[p] != scld_pkg::ChSpace) p++;
    l2 = p - s2;
    e = '0;
    e.kind = 1'b1;
    e.code = scld_pkg::CodeBlank;
    if (l1 == 0) return e;
    e.code = scld_pkg::CodeUnknown;
    for (int k = 0; k < scld_pkg::KeywordCount; k++) begin
      if (tok_is(s1, l1, kw[k])) begin
        e.code = k[4:0];
        break;
      end
    end
    if (l2 == 0) return e;
    e.present = 1'b1;
    e.is_on = tok_is(s2, l2, "ON");
    e.is_off = tok_is(s2, l2, "OFF");
    e.value = tok_value(s2, l2);
    return e;
  endfunction

  assign pending_o = event_q.size();

  // Predict on accepted receive words, compare accepted event words
  always @(posedge clk_i or negedge rst_ni) begin
    event_t got, want;
    if (!rst_ni) begin
      line_len = 0;
      err_count_o = 0;
      event_q.delete();
    end else begin
      if (rx_valid_i && !rx_stall_i) begin
        if (rx_byte_i == scld_pkg::ChCr || rx_byte_i == scld_pkg::ChLf) begin
          if (line_len != 0) begin
            event_q.push_back(decode_line());
            line_len = 0;
          end
        end else if (rx_byte_i == scld_pkg::ChBs || rx_byte_i == scld_pkg::ChDel) begin
          if (line_len != 0) begin
            line_len--;
            event_q.push_back('0);
          end
        end else if (line_len < scld_pkg::LineCapacity) begin
          line_buf[line_len] = rx_byte_i;
          line_len++;
        end
      end
      if (ev_valid_i && !ev_stall_i) begin
        got = '{event_kind_i, command_code_i, arg_present_i, arg_is_on_i,
                arg_is_off_i, arg_value_i};
        if (event_q.size() == 0) begin
          $error("unexpected event word kind=%0d code=%0d", got.kind, got.code);
          err_count_o++;
        end else begin
          want = event_q.pop_front();
          if (got.kind != want.kind) begin
            $error("event_kind: expected %0d actual %0d", want.kind, got.kind);
            err_count_o++;
          end
          if (got.code != want.code) begin
            $error("command_code: expected %0d actual %0d", want.code, got.code);
            err_count_o++;
          end
          if (got.present != want.present) begin
            $error("arg_present: expected %0d actual %0d", want.present, got.present);
            err_count_o++;
          end
          if (got.is_on != want.is_on) begin
            $error("arg_is_on: expected %0d actual %0d", want.is_on, got.is_on);
            err_count_o++;
          end
          if (got.is_off != want.is_off) begin
            $error("arg_is_off: expected %0d actual %0d", want.is_off, got.is_off);
            err_count_o++;
          end
          if (got.value != want.value) begin
            $error("arg_value: expected %0d actual %0d", $signed(want.value),
                   $signed(got.value));
            err_count_o++;
          end
        end
      end
    end
  end

endmodule

FILE: tb/sv/serial_command_line_decoder_core_tb.sv
// Testbench top: drives command lines into the decoder and gives the verdict.
module serial_command_line_decoder_core_tb;

  localparam int CycleLimit = 1500000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        rx_valid_i = 1'b0;
  logic        rx_stall_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        ev_valid_o;
  logic        ev_stall_i = 1'b0;
  logic        event_kind_o;
  logic [4:0]  command_code_o;
  logic        arg_present_o;
  logic        arg_is_on_o;
  logic        arg_is_off_o;
  logic signed [31:0] arg_value_o;
  int          err_count;
  int          pending;
  int          send_idle_pct = 7;
  int          recv_idle_pct = 79;
  int          hold_cycles = 0;
  int          cycle_count = 0;
  int          word_count = 0;

  always #5 clk_i = ~clk_i;

  serial_command_line_decoder_core u_top (.*);

  serial_command_line_decoder_core_chk u_chk (
    .clk_i, .rst_ni, .rx_valid_i, .rx_stall_i(rx_stall_o), .rx_byte_i,
    .ev_valid_i(ev_valid_o), .ev_stall_i, .event_kind_i(event_kind_o),
    .command_code_i(command_code_o), .arg_present_i(arg_present_o),
    .arg_is_on_i(arg_is_on_o), .arg_is_off_i(arg_is_off_o),
    .arg_value_i(arg_value_o), .err_count_o(err_count), .pending_o(pending)
  );

  // Stall the event channel at random, or for a whole hold-off stretch
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      ev_stall_i <= 1'b1;
    end else begin
      ev_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("serial_command_line_decoder_core_tb: errors");
      $finish;
    end
  end

  // Offer one word and hold it until accepted; valid drops only on idle cycles
  task automatic send_word(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (rx_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    word_count++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i]);
  endtask

  // Random token drawn mostly from keywords and argument forms
  function automatic string pick_token(input bit arg);
    string kw[scld_pkg::KeywordCount] = '{"LED", "INTERVAL", "HELLO", "DUMP", "HELP",
      "UPTIME", "BRIGHT", "STATUS", "BREATH", "BLINK", "BREATHSPEED", "RESET", "TIMER",
      "ENV", "REPORT", "DEBUG", "SENSSTAT"};
    string t;
    int    n;
    case ($urandom_range(5))
      0: t = arg ? "ON" : kw[$urandom_range(scld_pkg::KeywordCount - 1)];
      1: t = arg ? "OFF" : kw[$urandom_range(scld_pkg::KeywordCount - 1)].tolower();
      2: t = $sformatf("%0d", $signed($urandom()));
      3: begin
        t = ($urandom_range(1) != 0) ? "-" : "+";
        n = $urandom_range(14);
        for (int i = 0; i < n; i++) t = {t, string'(8'("0" + $urandom_range(9)))};
      end
      4: t = kw[$urandom_range(scld_pkg::KeywordCount - 1)];
      default: begin
        t = "";
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) t = {t, string'(8'($urandom_range(33, 126)))};
      end
    endcase
    return t;
  endfunction

  // Send a random line: tokens with space runs, sometimes edits or noise
  task automatic send_random_line();
    int    ntok;
    string t;
    ntok = $urandom_range(0, 3);
    for (int i = 0; i < ntok; i++) begin
      repeat ($urandom_range(i == 0 ? 0 : 1, 2)) send_word(scld_pkg::ChSpace);
      t = pick_token(i != 0);
      if (i == 1 && $urandom_range(9) == 0) t = {string'(8'($urandom_range(9, 13))), t};
      send_text(t);
    end
    case ($urandom_range(9))
      0: send_word(scld_pkg::ChBs);
      1: send_word(scld_pkg::ChDel);
      2: send_word(8'($urandom()));
      3: send_word(scld_pkg::ChNul);
      default: ;
    endcase
    send_word(($urandom_range(1) != 0) ? scld_pkg::ChCr : scld_pkg::ChLf);
  endtask

  task automatic run_random(input int n);
    int stop;
    stop = word_count + n;
    while (word_count < stop) send_random_line();
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty-line controls, keywords, arguments, saturation, NUL, full line
    send_word(scld_pkg::ChCr);
    send_word(scld_pkg::ChBs);
    send_text("LED ON\r");
    send_text("  BREATHSPEED   OFF x\n");
    send_text("SENSSTAT -2147483649\r");
    send_text("TIMER 99999999999\r");
    send_text("ENV\t+12a\r");
    send_text("   \r");
    send_text("HELX");
    send_word(scld_pkg::ChDel);
    send_text("P ");
    send_word(scld_pkg::ChNul);
    send_text("7\r");
    send_word(8'hFF);
    send_word(scld_pkg::ChBs);
    send_word(scld_pkg::ChLf);
    for (int i = 0; i < 70; i++) send_word(8'(8'h41 + (i % 26)));
    send_word(scld_pkg::ChCr);

    // Random phases with changing idle rates, one long hold-off
    run_random(600);
    send_idle_pct = 79;
    recv_idle_pct = 7;
    hold_cycles = 400;
    run_random(600);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(400);
    rx_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (err_count == 0) begin
      $display("serial_command_line_decoder_core_tb: clean");
    end else begin
      $display("serial_command_line_decoder_core_tb: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/scld_pkg.sv
rtl/scld_ram.sv
rtl/serial_command_line_decoder_core.sv
tb/sv/serial_command_line_decoder_core_chk.sv
tb/sv/serial_command_line_decoder_core_tb.sv
